// File: hdl/pkct_pkg.sv
// pkct_pkg: shared types and constants of the per-key change event throttle
// used by pkct_ctrl, pkct_dpath and the top level; no dependencies
package pkct_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [2:0] KIND_CHANGED   = 3'd0;
  localparam logic [2:0] KIND_DONE_HINT = 3'd1;

  localparam logic [19:0] RATE_LIMIT_RESET = 20'd800;
  localparam logic [15:0] DONE_DELAY_RESET = 16'd2000;

  localparam logic REG_RATE_LIMIT = 1'b0;
  localparam logic REG_DONE_DELAY = 1'b1;

  typedef enum logic [1:0] {
    PUT_CHANGE_SYN,
    PUT_DONE_SYN,
    PUT_EVENT,
    PUT_UNTRACKED
  } put_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_TICK,
    WR_FLUSH_C,
    WR_CLR_HD,
    WR_CHANGE
  } wr_op_t;

  typedef struct packed {
    logic     latch;
    logic     look;
    logic     idx_clr;
    logic     idx_inc;
    logic     put;
    put_sel_t put_sel;
    logic     finish;
    wr_op_t   wr;
  } cmd_t;

  typedef struct packed {
    logic in_tick;
    logic look_hit;
    logic look_full;
    logic hit;
    logic full;
    logic valid_at;
    logic fire_c;
    logic fire_d;
    logic dd_nz;
    logic hd_nz;
    logic pass;
    logic idx_last;
    logic slot_ok;
    logic out_free;
    logic hold_valid;
    logic kind_changed;
    logic kind_done;
  } status_t;

endpackage

// File: hdl/pkct_dpath.sv
// pkct_dpath: entry table, configuration registers, lookup, time arithmetic
// and the two-deep result buffer; depends on pkct_pkg
module pkct_dpath import pkct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     st,
  input  logic        opcode,
  input  logic [31:0] now_ms,
  input  logic [31:0] file_key,
  input  logic [31:0] other_key,
  input  logic        has_other,
  input  logic [2:0]  event_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_key,
  output logic [31:0] out_other_key,
  output logic        out_has_other,
  output logic [2:0]  out_kind,
  output logic        untracked,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  logic [19:0] rate_limit;
  logic [15:0] done_delay;

  logic [TABLE_ENTRIES-1:0] evalid;
  logic [31:0] ekey [TABLE_ENTRIES];
  logic [31:0] els  [TABLE_ENTRIES];
  logic [31:0] edd  [TABLE_ENTRIES];
  logic [31:0] ehd  [TABLE_ENTRIES];

  logic [31:0] l_now, l_key, l_other;
  logic        l_has;
  logic [2:0]  l_kind;

  logic [IDX_W-1:0] idx;
  logic             hit, full;

  // lookup over all entries in parallel
  logic [IDX_W-1:0] match_idx, free_idx;
  logic             any_match, any_free;

  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    any_match = 1'b0;
    any_free  = 1'b0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (evalid[i] && ekey[i] == l_key) begin
        any_match = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (!evalid[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  logic [31:0] rk, rls, rdd, rhd;
  logic        rv;
  assign rk  = ekey[idx];
  assign rls = els[idx];
  assign rdd = edd[idx];
  assign rhd = ehd[idx];
  assign rv  = evalid[idx];

  logic        fire_c, fire_d, keep;
  logic [31:0] ls_after, expire, since, dd_arm, hd_arm;

  assign fire_c   = (rdd != 32'd0) && (l_now >= rdd);
  assign fire_d   = (rhd != 32'd0) && (l_now >= rhd);
  assign ls_after = fire_c ? l_now : rls;
  assign expire   = ls_after + {11'd0, rate_limit, 1'b0};
  assign keep     = ((ls_after != 32'd0) && (expire > l_now))
                  || (!fire_c && rdd != 32'd0) || (!fire_d && rhd != 32'd0);
  assign since    = (rls > l_now) ? 32'd0 : l_now - rls;
  assign dd_arm   = l_now + {12'd0, rate_limit};
  assign hd_arm   = l_now + {16'd0, done_delay};

  logic pass;
  assign pass = !hit || (since >= {12'd0, rate_limit});

  // result buffer: hold stage so the last result of an item can be marked
  logic        hold_valid;
  logic [31:0] h_key, h_other;
  logic        h_has, h_untr;
  logic [2:0]  h_kind;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  logic [31:0] n_key, n_other;
  logic        n_has, n_untr;
  logic [2:0]  n_kind;

  always_comb begin
    n_key   = l_key;
    n_other = l_has ? l_other : 32'd0;
    n_has   = l_has;
    n_kind  = l_kind;
    n_untr  = 1'b0;
    case (cmd.put_sel)
      PUT_CHANGE_SYN: begin
        n_key = rk; n_other = 32'd0; n_has = 1'b0; n_kind = KIND_CHANGED;
      end
      PUT_DONE_SYN: begin
        n_key = rk; n_other = 32'd0; n_has = 1'b0; n_kind = KIND_DONE_HINT;
      end
      PUT_UNTRACKED: begin
        n_kind = KIND_CHANGED; n_untr = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit <= RATE_LIMIT_RESET;
      done_delay <= DONE_DELAY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE_LIMIT: rate_limit <= cfg_data;
        REG_DONE_DELAY: done_delay <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      l_now   <= now_ms;
      l_key   <= file_key;
      l_other <= other_key;
      l_has   <= has_other;
      l_kind  <= event_kind;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end else if (cmd.look) begin
      idx  <= any_match ? match_idx : free_idx;
      hit  <= any_match;
      full <= !any_free;
    end
    case (cmd.wr)
      WR_TICK: begin
        els[idx] <= ls_after;
        if (fire_c) edd[idx] <= 32'd0;
        if (fire_d) ehd[idx] <= 32'd0;
      end
      WR_FLUSH_C: begin
        if (rdd != 32'd0) begin
          edd[idx] <= 32'd0;
          els[idx] <= l_now;
        end
      end
      WR_CLR_HD: ehd[idx] <= 32'd0;
      WR_CHANGE: begin
        if (!hit) begin
          ekey[idx] <= l_key;
          els[idx]  <= l_now;
          edd[idx]  <= 32'd0;
        end else if (pass) begin
          els[idx] <= l_now;
          edd[idx] <= 32'd0;
        end else if (rdd == 32'd0) begin
          edd[idx] <= dd_arm;
        end
        ehd[idx] <= hd_arm;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evalid <= '0;
    end else if (cmd.wr == WR_TICK) begin
      evalid[idx] <= keep;
    end else if (cmd.wr == WR_CHANGE && !hit) begin
      evalid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.put) begin
        hold_valid <= 1'b1;
        h_key   <= n_key;
        h_other <= n_other;
        h_has   <= n_has;
        h_kind  <= n_kind;
        h_untr  <= n_untr;
      end else if (cmd.finish) begin
        hold_valid <= 1'b0;
      end
      if ((cmd.put && hold_valid) || cmd.finish) begin
        out_valid     <= 1'b1;
        out_key       <= h_key;
        out_other_key <= h_other;
        out_has_other <= h_has;
        out_kind      <= h_kind;
        untracked     <= h_untr;
        last_of_run   <= cmd.finish;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    st.in_tick      = opcode;
    st.look_hit     = any_match;
    st.look_full    = !any_free;
    st.hit          = hit;
    st.full         = full;
    st.valid_at     = rv;
    st.fire_c       = fire_c;
    st.fire_d       = fire_d;
    st.dd_nz        = rdd != 32'd0;
    st.hd_nz        = rhd != 32'd0;
    st.pass         = pass;
    st.idx_last     = idx == IDX_W'(TABLE_ENTRIES - 1);
    st.slot_ok      = !hold_valid || out_free;
    st.out_free     = out_free;
    st.hold_valid   = hold_valid;
    st.kind_changed = l_kind == KIND_CHANGED;
    st.kind_done    = l_kind == KIND_DONE_HINT;
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid && last_of_run && !hold_valid)
    else $error("finish did not move the held result out as last");
  assert property (@(posedge clk) disable iff (rst)
    cmd.put && !hold_valid |=> hold_valid && !(out_valid && !$past(out_valid)))
    else $error("first result of a run reached the output early");
  assert property (@(posedge clk) disable iff (rst)
    (cmd.wr == WR_CHANGE) && !hit |=> evalid[$past(idx)])
    else $error("allocated entry not marked valid");

endmodule

// File: hdl/pkct_ctrl.sv
// pkct_ctrl: sequencer for lookup, tick scan and result issue
// depends on pkct_pkg; drives pkct_dpath through cmd_t and reads status_t
module pkct_ctrl import pkct_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOOK = 9'b000000010,
    S_TC   = 9'b000000100,
    S_TD   = 9'b000001000,
    S_EFC  = 9'b000010000,
    S_EFD  = 9'b000100000,
    S_EPUT = 9'b001000000,
    S_ECHG = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.put_sel = PUT_EVENT;
    cmd.wr = WR_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next = st.in_tick ? S_TC : S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        if (st.kind_changed) state_next = S_ECHG;
        else state_next = st.look_hit ? S_EFC : S_EPUT;
      end
      S_TC: begin
        if (!st.valid_at) begin
          if (st.idx_last) state_next = S_FIN;
          else cmd.idx_inc = 1'b1;
        end else if (!st.fire_c) begin
          state_next = S_TD;
        end else if (st.slot_ok) begin
          cmd.put = 1'b1;
          cmd.put_sel = PUT_CHANGE_SYN;
          state_next = S_TD;
        end
      end
      S_TD: begin
        if (!st.fire_d || st.slot_ok) begin
          cmd.put = st.fire_d;
          cmd.put_sel = PUT_DONE_SYN;
          cmd.wr = WR_TICK;
          if (st.idx_last) state_next = S_FIN;
          else begin
            cmd.idx_inc = 1'b1;
            state_next = S_TC;
          end
        end
      end
      S_EFC: begin
        if (!st.dd_nz) state_next = S_EFD;
        else if (st.slot_ok) begin
          cmd.put = 1'b1;
          cmd.put_sel = PUT_CHANGE_SYN;
          cmd.wr = WR_FLUSH_C;
          state_next = S_EFD;
        end
      end
      S_EFD: begin
        if (st.kind_done || !st.hd_nz) begin
          cmd.wr = WR_CLR_HD;
          state_next = S_EPUT;
        end else if (st.slot_ok) begin
          cmd.put = 1'b1;
          cmd.put_sel = PUT_DONE_SYN;
          cmd.wr = WR_CLR_HD;
          state_next = S_EPUT;
        end
      end
      S_EPUT: begin
        if (st.slot_ok) begin
          cmd.put = 1'b1;
          state_next = S_FIN;
        end
      end
      S_ECHG: begin
        if (!st.hit && st.full) begin
          if (st.slot_ok) begin
            cmd.put = 1'b1;
            cmd.put_sel = PUT_UNTRACKED;
            state_next = S_FIN;
          end
        end else if (!st.pass || st.slot_ok) begin
          cmd.put = st.pass;
          cmd.wr = WR_CHANGE;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!st.hold_valid) state_next = S_IDLE;
        else if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assert property (@(posedge clk) disable iff (rst) cmd.put |-> st.slot_ok)
    else $error("result issued with no room in the buffer");
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> st.hold_valid && st.out_free)
    else $error("finish without a held result or a free output");
  assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !st.hold_valid)
    else $error("held result left behind at end of item");

endmodule

// File: hdl/per_key_change_event_throttle_unit.sv
// per-key change event throttle: an event is latched, looked up over all keys
// in parallel and issues its reports in turn; a tick walks the 16-entry table
// one empty entry a cycle, a second state for a live entry, plus output stalls.
// one item at a time; the next is taken once the last report is handed to the
// output register. synchronous reset clears the valid bits, restores both
// limits to defaults and empties the output.
module per_key_change_event_throttle_unit import pkct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [31:0] now_ms,
  input  logic [31:0] file_key,
  input  logic [31:0] other_key,
  input  logic        has_other,
  input  logic [2:0]  event_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_key,
  output logic [31:0] out_other_key,
  output logic        out_has_other,
  output logic [2:0]  out_kind,
  output logic        untracked,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  cmd_t    cmd;
  status_t st;

  pkct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  pkct_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .opcode        (opcode),
    .now_ms        (now_ms),
    .file_key      (file_key),
    .other_key     (other_key),
    .has_other     (has_other),
    .event_kind    (event_kind),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_key       (out_key),
    .out_other_key (out_other_key),
    .out_has_other (out_has_other),
    .out_kind      (out_kind),
    .untracked     (untracked),
    .last_of_run   (last_of_run),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

endmodule
